@@ design/sbt_pkg.sv @@
// ----------------------------------------------------------------------------
// Source byte tokenizer package
// Token kinds, scan modes, character constants, the result record and the
// keyword spelling table shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package sbt_pkg;

  // Token kinds as reported on the result channel.
  localparam logic [2:0] KIND_IDENT    = 3'd0;
  localparam logic [2:0] KIND_KEYWORD  = 3'd1;
  localparam logic [2:0] KIND_NUMBER   = 3'd2;
  localparam logic [2:0] KIND_OPERATOR = 3'd3;
  localparam logic [2:0] KIND_STRING   = 3'd4;
  localparam logic [2:0] KIND_SYMBOL   = 3'd5;
  localparam logic [2:0] KIND_EOF      = 3'd6;

  // Scan modes.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_STRING = 2'd3;

  // Input commands.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int KW_COUNT = 4;

  // Keyword lengths: class, void, int, string.
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd4, 3'd3, 3'd6};

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] kw_live;
  } sbt_ctrl_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] start;
    logic [15:0] length;
    logic [7:0]  first;
    logic        last;
  } sbt_result_t;

  // Character at position idx of keyword kw; zero beyond the spelling.
  function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (kw)
      2'd0: begin
        unique case (idx)
          3'd0: ch = "c";
          3'd1: ch = "l";
          3'd2: ch = "a";
          3'd3: ch = "s";
          3'd4: ch = "s";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (idx)
          3'd0: ch = "v";
          3'd1: ch = "o";
          3'd2: ch = "i";
          3'd3: ch = "d";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (idx)
          3'd0: ch = "i";
          3'd1: ch = "n";
          3'd2: ch = "t";
          default: ch = 8'h00;
        endcase
      end
      2'd3: begin
        unique case (idx)
          3'd0: ch = "s";
          3'd1: ch = "t";
          3'd2: ch = "r";
          3'd3: ch = "i";
          3'd4: ch = "n";
          3'd5: ch = "g";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == CH_SPACE);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_EQUAL) || (c == CH_PLUS) || (c == CH_MINUS) ||
           (c == CH_LBRACE) || (c == CH_RBRACE);
  endfunction

endpackage

@@ design/sbt_scan.sv @@
// ----------------------------------------------------------------------------
// Tokenizer scan step
// Next-state and result logic for one source byte or end-of-source command.
// ----------------------------------------------------------------------------
module sbt_scan #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic                     cmd,
  input  logic [7:0]               byte_in,
  input  sbt_pkg::sbt_ctrl_t       ctrl_i,
  input  logic [OFFSET_BITS-1:0]   cur_i,
  input  logic [OFFSET_BITS-1:0]   start_i,
  input  logic [LENGTH_BITS-1:0]   len_i,
  input  logic [7:0]               first_i,
  output sbt_pkg::sbt_ctrl_t       ctrl_o,
  output logic [OFFSET_BITS-1:0]   cur_o,
  output logic [OFFSET_BITS-1:0]   start_o,
  output logic [LENGTH_BITS-1:0]   len_o,
  output logic [7:0]               first_o,
  output logic                     res0_valid,
  output sbt_pkg::sbt_result_t     res0,
  output logic                     res1_valid,
  output sbt_pkg::sbt_result_t     res1
);
  import sbt_pkg::*;

  logic [OFFSET_BITS-1:0] cur_inc;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [3:0]             kw_ok;
  logic [3:0]             kw_first_ok;
  logic [3:0]             kw_hit;
  logic [2:0]             close_kind;
  logic                   close_v;
  logic                   idle_v;
  sbt_result_t            close_r;
  sbt_result_t            idle_r;
  logic                   open_v;

  assign cur_inc = (cur_i == '1) ? cur_i : cur_i + 1'b1;
  assign len_inc = (len_i == '1) ? len_i : len_i + 1'b1;

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_ok[k]       = (len_i < LENGTH_BITS'(KW_LEN[k])) &&
                       (kw_char(2'(k), len_i[2:0]) == byte_in);
      kw_first_ok[k] = (kw_char(2'(k), 3'd0) == byte_in);
      kw_hit[k]      = (len_i == LENGTH_BITS'(KW_LEN[k]));
    end
  end

  always_comb begin
    unique case (ctrl_i.mode)
      MODE_IDENT:  close_kind = (|(ctrl_i.kw_live & kw_hit)) ? KIND_KEYWORD : KIND_IDENT;
      MODE_NUMBER: close_kind = KIND_NUMBER;
      MODE_STRING: close_kind = KIND_STRING;
      default:     close_kind = KIND_IDENT;
    endcase
  end

  assign open_v = (ctrl_i.mode != MODE_IDLE);

  always_comb begin
    close_r.kind   = close_kind;
    close_r.start  = 32'(start_i);
    close_r.length = 16'(len_i);
    close_r.first  = first_i;
    close_r.last   = 1'b0;

    idle_r.kind    = KIND_SYMBOL;
    idle_r.start   = 32'(cur_i);
    idle_r.length  = 16'd1;
    idle_r.first   = byte_in;
    idle_r.last    = 1'b1;

    close_v = 1'b0;
    idle_v  = 1'b0;
    ctrl_o  = ctrl_i;
    cur_o   = cur_i;
    start_o = start_i;
    len_o   = len_i;
    first_o = first_i;

    if (cmd == CMD_END) begin
      // Close any open token, report end of file, then start a new source.
      close_v        = open_v;
      idle_v         = 1'b1;
      idle_r.kind    = KIND_EOF;
      idle_r.length  = 16'd0;
      idle_r.first   = 8'h00;
      ctrl_o.mode    = MODE_IDLE;
      ctrl_o.kw_live = 4'hf;
      cur_o          = '0;
      start_o        = '0;
      len_o          = '0;
      first_o        = 8'h00;
    end else begin
      cur_o = cur_inc;
      priority if ((ctrl_i.mode == MODE_STRING) && (byte_in != CH_QUOTE)) begin
        if (len_i == '0) begin
          first_o = byte_in;
        end
        len_o = len_inc;
      end else if (ctrl_i.mode == MODE_STRING) begin
        close_v     = 1'b1;
        ctrl_o.mode = MODE_IDLE;
      end else if ((ctrl_i.mode == MODE_IDENT) &&
                   (is_alpha(byte_in) || is_digit(byte_in) || (byte_in == CH_UNDER))) begin
        ctrl_o.kw_live = ctrl_i.kw_live & kw_ok;
        len_o          = len_inc;
      end else if ((ctrl_i.mode == MODE_NUMBER) && is_digit(byte_in)) begin
        len_o = len_inc;
      end else begin
        // The byte ends any open token and is then scanned between tokens.
        close_v     = open_v;
        ctrl_o.mode = MODE_IDLE;
        priority if (is_space(byte_in)) begin
          idle_v = 1'b0;
        end else if (is_alpha(byte_in) || (byte_in == CH_UNDER)) begin
          ctrl_o.mode    = MODE_IDENT;
          ctrl_o.kw_live = kw_first_ok;
          start_o        = cur_i;
          len_o          = LENGTH_BITS'(1);
          first_o        = byte_in;
        end else if (is_digit(byte_in)) begin
          ctrl_o.mode    = MODE_NUMBER;
          ctrl_o.kw_live = 4'hf;
          start_o        = cur_i;
          len_o          = LENGTH_BITS'(1);
          first_o        = byte_in;
        end else if (byte_in == CH_QUOTE) begin
          // String contents start after the quote.
          ctrl_o.mode    = MODE_STRING;
          ctrl_o.kw_live = 4'hf;
          start_o        = cur_inc;
          len_o          = '0;
          first_o        = 8'h00;
        end else if (is_operator(byte_in)) begin
          idle_v      = 1'b1;
          idle_r.kind = KIND_OPERATOR;
        end else begin
          idle_v      = 1'b1;
          idle_r.kind = KIND_SYMBOL;
        end
      end
    end
  end

  always_comb begin
    res0_valid = close_v || idle_v;
    res1_valid = close_v && idle_v;
    res0       = close_v ? close_r : idle_r;
    res0.last  = !(close_v && idle_v);
    res1       = idle_r;
    res1.last  = 1'b1;
  end

endmodule

@@ design/sbt_result_fifo.sv @@
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Four-entry queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module sbt_result_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr0,
  input  sbt_pkg::sbt_result_t wd0,
  input  logic                 wr1,
  input  sbt_pkg::sbt_result_t wd1,
  output logic                 room2,
  output logic                 rd_valid,
  output sbt_pkg::sbt_result_t rd_data,
  input  logic                 rd_ready
);
  import sbt_pkg::*;

  localparam int DEPTH = 4;

  sbt_result_t mem_r [DEPTH];
  logic [1:0]  wptr_r;
  logic [1:0]  wptr_nxt;
  logic [1:0]  rptr_r;
  logic [1:0]  rptr_nxt;
  logic [2:0]  count_r;
  logic [2:0]  count_nxt;
  logic        pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (count_r != 3'd0);
  assign rd_data  = mem_r[rptr_r];
  assign room2    = (count_r <= 3'(DEPTH - 2));

  assign wptr_nxt  = wptr_r + {1'b0, wr0} + {1'b0, wr1};
  assign rptr_nxt  = rptr_r + {1'b0, pop};
  assign count_nxt = count_r + {2'b00, wr0} + {2'b00, wr1} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (wr0) begin
      mem_r[wptr_r] <= wd0;
    end
    if (wr1) begin
      mem_r[wptr_r + 2'd1] <= wd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ design/source_byte_tokenizer.sv @@
// ----------------------------------------------------------------------------
// Source byte tokenizer
// Splits a byte stream of source text into identifier, keyword, number,
// operator, string and symbol tokens, with an end-of-file token at the end.
// ----------------------------------------------------------------------------
//
//   channel  direction  tdata                          tuser          tlast
//   in_      slave      source_byte [7:0]              command [0]    -
//   out_     master     start/length/first_char [55:0] token_kind     last_of_run
//
// Flow: one byte transfer per clock is accepted sustained while the result
// queue has room for two results; each item waits in the input register
// and its results go into the result queue when scanned, then to the out_ port.
// A byte that both closes a token and forms one of its own yields two results,
// and the output port's one transfer per cycle sets the rate in that case.
// Reset is synchronous on rst_n and puts the scanner between tokens at
// offset zero; no clearing pass is needed.
// Stalls: in_tready drops only when the input register is full and the
// result queue has fewer than two free entries.
module source_byte_tokenizer #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  input  logic        in_tuser,   // [0] command: 0 byte, 1 end of source
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] token_start, [47:32] token_length,
                                  // [55:48] first_char
  output logic [2:0]  out_tuser,  // [2:0] token_kind
  output logic        out_tlast   // last_of_run
);
  import sbt_pkg::*;

  // Input register: one accepted transfer waits here for the scan step.
  logic                   in_valid_r;
  logic                   in_cmd_r;
  logic [7:0]             in_byte_r;
  logic                   consume;
  logic                   room2;

  // Scanner state.
  sbt_ctrl_t              ctrl_r;
  sbt_ctrl_t              ctrl_nxt;
  logic [OFFSET_BITS-1:0] cur_r;
  logic [OFFSET_BITS-1:0] cur_nxt;
  logic [OFFSET_BITS-1:0] start_r;
  logic [OFFSET_BITS-1:0] start_nxt;
  logic [LENGTH_BITS-1:0] len_r;
  logic [LENGTH_BITS-1:0] len_nxt;
  logic [7:0]             first_r;
  logic [7:0]             first_nxt;

  logic                   res0_valid;
  logic                   res1_valid;
  sbt_result_t            res0;
  sbt_result_t            res1;
  sbt_result_t            head;

  // The held item is scanned once the queue can take both of its results,
  // and the input register refills in the same cycle.
  assign consume   = in_valid_r && room2;
  assign in_tready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r  <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  sbt_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_scan (
    .cmd        (in_cmd_r),
    .byte_in    (in_byte_r),
    .ctrl_i     (ctrl_r),
    .cur_i      (cur_r),
    .start_i    (start_r),
    .len_i      (len_r),
    .first_i    (first_r),
    .ctrl_o     (ctrl_nxt),
    .cur_o      (cur_nxt),
    .start_o    (start_nxt),
    .len_o      (len_nxt),
    .first_o    (first_nxt),
    .res0_valid (res0_valid),
    .res0       (res0),
    .res1_valid (res1_valid),
    .res1       (res1)
  );

  // Scanner state is architectural: reset puts it at the start of a source.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.mode    <= MODE_IDLE;
      ctrl_r.kw_live <= 4'hf;
      cur_r          <= '0;
      start_r        <= '0;
      len_r          <= '0;
      first_r        <= 8'h00;
    end else if (consume) begin
      ctrl_r  <= ctrl_nxt;
      cur_r   <= cur_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      first_r <= first_nxt;
    end
  end

  sbt_result_fifo u_results (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr0      (consume && res0_valid),
    .wd0      (res0),
    .wr1      (consume && res1_valid),
    .wd1      (res1),
    .room2    (room2),
    .rd_valid (out_tvalid),
    .rd_data  (head),
    .rd_ready (out_tready)
  );

  assign out_tdata = {head.first, head.length, head.start};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

@@ design/sbt_checker.sv @@
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Checks result records seen on the top-level ports and binds to the top.
// ----------------------------------------------------------------------------
module sbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import sbt_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // End of file carries no length or first character and ends its run.
  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_EOF) |-> out_tlast && (out_tdata[55:32] == 24'd0))
    else $error("malformed end-of-file result");

  // Operators and symbols are single bytes and always end their run.
  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == KIND_OPERATOR) || (out_tuser == KIND_SYMBOL)) |->
      out_tlast && (out_tdata[47:32] == 16'd1))
    else $error("operator or symbol result malformed");

  // Only a closed token can precede another result from the same byte.
  a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      (out_tuser == KIND_IDENT) || (out_tuser == KIND_KEYWORD) ||
      (out_tuser == KIND_NUMBER) || (out_tuser == KIND_STRING))
    else $error("unexpected kind on a non-final result");

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
